/* design/dftlb_pkg.sv */
// dftlb_pkg: widths, register map and reset values for the daily fan timer
// with led blink; used by daily_fan_timer_with_led_blink
// no dependencies
`timescale 1ns / 1ps

package dftlb_pkg;

  localparam int CLK_W   = 37;
  localparam int BLINK_W = 32;
  localparam int OVF_W   = 16;
  localparam int PER_W   = 24;
  localparam int DUTY_W  = 8;
  localparam int POT_W   = 8;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERFLOW_PERIOD = 3'd0,
    REG_SERVICE_PERIOD  = 3'd1,
    REG_FAN_ON_WINDOW   = 3'd2,
    REG_DAY_LENGTH      = 3'd3,
    REG_WARNING_WINDOW  = 3'd4,
    REG_SLOW_BLINK      = 3'd5,
    REG_FAST_BLINK      = 3'd6,
    REG_MIN_FAN_SPEED   = 3'd7
  } cfg_reg_t;

  localparam logic [OVF_W-1:0]  RST_OVERFLOW_PERIOD = 16'd16384;
  localparam logic [PER_W-1:0]  RST_SERVICE_PERIOD  = 24'd250000;
  localparam logic [CLK_W-1:0]  RST_FAN_ON_WINDOW   = 37'd3600000000;
  localparam logic [CLK_W-1:0]  RST_DAY_LENGTH      = 37'd86400000000;
  localparam logic [CLK_W-1:0]  RST_WARNING_WINDOW  = 37'd10800000000;
  localparam logic [PER_W-1:0]  RST_SLOW_BLINK      = 24'd5000000;
  localparam logic [PER_W-1:0]  RST_FAST_BLINK      = 24'd500000;
  localparam logic [DUTY_W-1:0] RST_MIN_FAN_SPEED   = 8'd60;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

endpackage

/* design/daily_fan_timer_with_led_blink.sv */
// daily_fan_timer_with_led_blink: day clock, service scheduling, fan duty and
// status led control; depends on dftlb_pkg
//
// usage:
//   in_*   : one beat per timer overflow, in_tdata[7:0] = pot_level
//   out_*  : one beat per input beat, in input order
//            out_tdata[7:0] pwm_duty, [8] fan_running, [9] led_lit, [10] serviced
//   cfg_*  : 64-bit apb-style register port, register i at byte address 8*i,
//            pready always high, reads return the register value
//   out_tvalid: rises once the beat has passed the input register
//            and then the result register
//   throughput: one beat per cycle while out_tready is high; the whole state
//            update is one pass of add/multiply/compare logic between the two
//            registers; reset (rst_n low, synchronous): clocks, blink timer,
//            led, fan and duty clear, registers take defaults, both stages empty
//   receiver stall: the result register holds; one more beat is taken into
//            the input register, then in_tready drops until out_tready returns
//   registers must be written only while no beat is in flight (not enforced)
`timescale 1ns / 1ps

module daily_fan_timer_with_led_blink (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pot_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] pwm_duty, [8] fan_running, [9] led_lit,
                                  // [10] serviced, [15:11] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [dftlb_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dftlb_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dftlb_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = dftlb_pkg::CLK_W;
  localparam int BW = dftlb_pkg::BLINK_W;
  localparam int OW = dftlb_pkg::OVF_W;
  localparam int PW = dftlb_pkg::PER_W;
  localparam int DW = dftlb_pkg::DUTY_W;
  localparam int DWD = dftlb_pkg::CFG_DATA_W;

  // configuration registers
  logic [OW-1:0] ovf_per_r;
  logic [PW-1:0] svc_per_r;
  logic [CW-1:0] fan_win_r;
  logic [CW-1:0] day_len_r;
  logic [CW-1:0] warn_win_r;
  logic [PW-1:0] slow_blink_r;
  logic [PW-1:0] fast_blink_r;
  logic [DW-1:0] min_speed_r;

  logic                 cfg_wr;
  dftlb_pkg::cfg_reg_t  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = dftlb_pkg::cfg_reg_t'(cfg_paddr[dftlb_pkg::CFG_ADDR_W-1 -: 3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_per_r    <= dftlb_pkg::RST_OVERFLOW_PERIOD;
      svc_per_r    <= dftlb_pkg::RST_SERVICE_PERIOD;
      fan_win_r    <= dftlb_pkg::RST_FAN_ON_WINDOW;
      day_len_r    <= dftlb_pkg::RST_DAY_LENGTH;
      warn_win_r   <= dftlb_pkg::RST_WARNING_WINDOW;
      slow_blink_r <= dftlb_pkg::RST_SLOW_BLINK;
      fast_blink_r <= dftlb_pkg::RST_FAST_BLINK;
      min_speed_r  <= dftlb_pkg::RST_MIN_FAN_SPEED;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dftlb_pkg::REG_OVERFLOW_PERIOD: ovf_per_r    <= cfg_pwdata[OW-1:0];
        dftlb_pkg::REG_SERVICE_PERIOD:  svc_per_r    <= cfg_pwdata[PW-1:0];
        dftlb_pkg::REG_FAN_ON_WINDOW:   fan_win_r    <= cfg_pwdata[CW-1:0];
        dftlb_pkg::REG_DAY_LENGTH:      day_len_r    <= cfg_pwdata[CW-1:0];
        dftlb_pkg::REG_WARNING_WINDOW:  warn_win_r   <= cfg_pwdata[CW-1:0];
        dftlb_pkg::REG_SLOW_BLINK:      slow_blink_r <= cfg_pwdata[PW-1:0];
        dftlb_pkg::REG_FAST_BLINK:      fast_blink_r <= cfg_pwdata[PW-1:0];
        dftlb_pkg::REG_MIN_FAN_SPEED:   min_speed_r  <= cfg_pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dftlb_pkg::REG_OVERFLOW_PERIOD: cfg_prdata = DWD'(ovf_per_r);
      dftlb_pkg::REG_SERVICE_PERIOD:  cfg_prdata = DWD'(svc_per_r);
      dftlb_pkg::REG_FAN_ON_WINDOW:   cfg_prdata = DWD'(fan_win_r);
      dftlb_pkg::REG_DAY_LENGTH:      cfg_prdata = DWD'(day_len_r);
      dftlb_pkg::REG_WARNING_WINDOW:  cfg_prdata = DWD'(warn_win_r);
      dftlb_pkg::REG_SLOW_BLINK:      cfg_prdata = DWD'(slow_blink_r);
      dftlb_pkg::REG_FAST_BLINK:      cfg_prdata = DWD'(fast_blink_r);
      dftlb_pkg::REG_MIN_FAN_SPEED:   cfg_prdata = DWD'(min_speed_r);
      default:                        cfg_prdata = '0;
    endcase
  end

  // input stage
  logic          s1_valid_r;
  logic [7:0]    s1_pot_r;
  logic          adv;
  logic          in_acc;

  assign adv       = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pot_r <= in_tdata[7:0];
    end
  end

  // block state
  logic [CW-1:0] day_clock_r, day_clock_nxt;
  logic [CW-1:0] nsp_r, nsp_nxt;
  logic [BW-1:0] blink_r, blink_nxt;
  logic          led_r, led_nxt;
  logic          fan_r, fan_nxt;
  logic [DW-1:0] duty_r, duty_nxt;
  logic          svc;

  always_comb begin
    logic [CW:0]     dc_sum;
    logic [CW-1:0]   dc;
    logic [CW:0]     nsp_sum;
    logic [BW:0]     bl_sum;
    logic [BW-1:0]   bl_sat;
    logic [CW:0]     warn_sum;
    logic [PW-1:0]   interval;
    logic [15:0]     prod;
    logic [16:0]     qsum;
    logic [DW:0]     duty_sum;
    logic            fan_on;
    logic            wrap;

    dc_sum   = {1'b0, day_clock_r} + (CW + 1)'(ovf_per_r);
    dc       = dc_sum[CW] ? {CW{1'b1}} : dc_sum[CW-1:0];
    svc      = nsp_r < dc;
    nsp_sum  = {1'b0, nsp_r} + (CW + 1)'(svc_per_r);
    bl_sum   = {1'b0, blink_r} + (BW + 1)'(svc_per_r);
    bl_sat   = bl_sum[BW] ? {BW{1'b1}} : bl_sum[BW-1:0];
    fan_on   = dc <= fan_win_r;
    warn_sum = {1'b0, dc} + {1'b0, warn_win_r};
    interval = (warn_sum >= {1'b0, day_len_r}) ? fast_blink_r : slow_blink_r;
    wrap     = dc > day_len_r;

    // pot*(255-min)/255 via exact reciprocal form for 16-bit numerators
    prod     = 16'(s1_pot_r) * 16'(dftlb_pkg::DUTY_FULL - min_speed_r);
    qsum     = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    duty_sum = (DW + 1)'(qsum[15:8]) + (DW + 1)'(min_speed_r);

    day_clock_nxt = day_clock_r;
    nsp_nxt       = nsp_r;
    blink_nxt     = blink_r;
    led_nxt       = led_r;
    fan_nxt       = fan_r;
    duty_nxt      = duty_r;

    if (adv) begin
      day_clock_nxt = dc;
      if (svc) begin
        nsp_nxt   = nsp_sum[CW] ? {CW{1'b1}} : nsp_sum[CW-1:0];
        blink_nxt = bl_sat;
        fan_nxt   = fan_on;
        if (fan_on) begin
          led_nxt  = 1'b1;
          duty_nxt = duty_sum[DW-1:0];
        end else begin
          duty_nxt = '0;
          if (bl_sat >= BW'(interval)) begin
            led_nxt   = !led_r;
            blink_nxt = '0;
          end
        end
        if (wrap) begin
          day_clock_nxt = '0;
          nsp_nxt       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_clock_r <= '0;
      nsp_r       <= '0;
      blink_r     <= '0;
      led_r       <= 1'b0;
      fan_r       <= 1'b0;
      duty_r      <= '0;
    end else begin
      day_clock_r <= day_clock_nxt;
      nsp_r       <= nsp_nxt;
      blink_r     <= blink_nxt;
      led_r       <= led_nxt;
      fan_r       <= fan_nxt;
      duty_r      <= duty_nxt;
    end
  end

  // result register
  logic        out_valid_r;
  logic [15:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {5'd0, svc, led_nxt, fan_nxt, duty_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* verif/tb_daily_fan_timer_with_led_blink.sv */
// tb_daily_fan_timer_with_led_blink: self-checking testbench for the daily fan
// timer; predicts every result beat and compares it field by field
// depends on dftlb_pkg and daily_fan_timer_with_led_blink
`timescale 1ns / 1ps

module tb_daily_fan_timer_with_led_blink;

  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic [dftlb_pkg::DUTY_W-1:0] duty;
    logic                         fan;
    logic                         led;
    logic                         serviced;
  } fan_beat_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [7:0]                       in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [15:0]                      out_tdata;
  logic                             cfg_psel;
  logic                             cfg_penable;
  logic                             cfg_pwrite;
  logic [dftlb_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [dftlb_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [dftlb_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                             cfg_pready;

  // register shadow
  logic [dftlb_pkg::OVF_W-1:0]  ovf_us     = dftlb_pkg::RST_OVERFLOW_PERIOD;
  logic [dftlb_pkg::PER_W-1:0]  svc_us     = dftlb_pkg::RST_SERVICE_PERIOD;
  logic [dftlb_pkg::CLK_W-1:0]  fan_win_us = dftlb_pkg::RST_FAN_ON_WINDOW;
  logic [dftlb_pkg::CLK_W-1:0]  day_len_us = dftlb_pkg::RST_DAY_LENGTH;
  logic [dftlb_pkg::CLK_W-1:0]  warn_us    = dftlb_pkg::RST_WARNING_WINDOW;
  logic [dftlb_pkg::PER_W-1:0]  slow_us    = dftlb_pkg::RST_SLOW_BLINK;
  logic [dftlb_pkg::PER_W-1:0]  fast_us    = dftlb_pkg::RST_FAST_BLINK;
  logic [dftlb_pkg::DUTY_W-1:0] min_duty   = dftlb_pkg::RST_MIN_FAN_SPEED;

  // timer state
  logic [dftlb_pkg::CLK_W-1:0]   day_us    = '0;
  logic [dftlb_pkg::CLK_W-1:0]   svc_pt_us = '0;
  logic [dftlb_pkg::BLINK_W-1:0] blink_us  = '0;
  logic                          led_on    = 1'b0;
  logic                          fan_on    = 1'b0;
  logic [dftlb_pkg::DUTY_W-1:0]  duty_held = '0;

  fan_beat_t expected_beats[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;
  int        rx_hold = 0;

  daily_fan_timer_with_led_blink DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** daily_fan_timer_with_led_blink: FAILED **");
      $finish;
    end
  end

  function automatic void flag_mismatch(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected %0h got %0h at %0t", what, want, got, $realtime);
  endfunction

  function automatic void shadow_write(input dftlb_pkg::cfg_reg_t r, input logic [63:0] v);
    case (r)
      dftlb_pkg::REG_OVERFLOW_PERIOD: ovf_us     = v[dftlb_pkg::OVF_W-1:0];
      dftlb_pkg::REG_SERVICE_PERIOD:  svc_us     = v[dftlb_pkg::PER_W-1:0];
      dftlb_pkg::REG_FAN_ON_WINDOW:   fan_win_us = v[dftlb_pkg::CLK_W-1:0];
      dftlb_pkg::REG_DAY_LENGTH:      day_len_us = v[dftlb_pkg::CLK_W-1:0];
      dftlb_pkg::REG_WARNING_WINDOW:  warn_us    = v[dftlb_pkg::CLK_W-1:0];
      dftlb_pkg::REG_SLOW_BLINK:      slow_us    = v[dftlb_pkg::PER_W-1:0];
      dftlb_pkg::REG_FAST_BLINK:      fast_us    = v[dftlb_pkg::PER_W-1:0];
      dftlb_pkg::REG_MIN_FAN_SPEED:   min_duty   = v[dftlb_pkg::DUTY_W-1:0];
      default: ;
    endcase
  endfunction

  // one timer overflow: advance the day clock, maybe run a control update
  function automatic void predict_overflow(input logic [dftlb_pkg::POT_W-1:0] pot);
    logic [dftlb_pkg::CLK_W:0]    wide;
    logic [dftlb_pkg::BLINK_W:0]  bwide;
    logic [15:0]                  scaled;
    logic [dftlb_pkg::DUTY_W-1:0] duty;
    logic [dftlb_pkg::PER_W-1:0]  interval;
    fan_beat_t                    beat;
    wide = {1'b0, day_us} + (dftlb_pkg::CLK_W+1)'(ovf_us);
    day_us = wide[dftlb_pkg::CLK_W] ? '1 : wide[dftlb_pkg::CLK_W-1:0];
    beat.serviced = 1'b0;
    if (svc_pt_us < day_us) begin
      beat.serviced = 1'b1;
      wide = {1'b0, svc_pt_us} + (dftlb_pkg::CLK_W+1)'(svc_us);
      svc_pt_us = wide[dftlb_pkg::CLK_W] ? '1 : wide[dftlb_pkg::CLK_W-1:0];
      bwide = {1'b0, blink_us} + (dftlb_pkg::BLINK_W+1)'(svc_us);
      blink_us = bwide[dftlb_pkg::BLINK_W] ? '1 : bwide[dftlb_pkg::BLINK_W-1:0];
      scaled = 16'(pot) * 16'(dftlb_pkg::DUTY_FULL - min_duty);
      duty = 8'(scaled / 16'd255) + min_duty;
      fan_on = (day_us <= fan_win_us);
      if (fan_on) begin
        led_on = 1'b1;
        duty_held = duty;
      end else begin
        duty_held = '0;
        // near day end: sum kept one bit wider than the clock
        wide = {1'b0, day_us} + {1'b0, warn_us};
        interval = (wide >= {1'b0, day_len_us}) ? fast_us : slow_us;
        if (blink_us >= dftlb_pkg::BLINK_W'(interval)) begin
          led_on = ~led_on;
          blink_us = '0;
        end
      end
      if (day_us > day_len_us) begin
        day_us = '0;
        svc_pt_us = '0;
      end
    end
    beat.duty = duty_held;
    beat.fan  = fan_on;
    beat.led  = led_on;
    expected_beats.push_back(beat);
  endfunction

  function automatic logic [dftlb_pkg::POT_W-1:0] rand_pot();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return dftlb_pkg::POT_W'($urandom_range(0, 255));
    endcase
  endfunction

  // zero, the given top value, raw 64-bit noise, or a value in the working range
  function automatic logic [63:0] pick_span(input int unsigned lo, input int unsigned hi,
                                            input logic [63:0] top);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return top;
      2: return {$urandom, $urandom};
      default: return 64'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic send_overflow(input logic [dftlb_pkg::POT_W-1:0] pot);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pot;
    do @(posedge clk); while (!in_tready);
    predict_overflow(pot);
    @(negedge clk);
  endtask

  // called at a falling edge; returns at a falling edge with nothing in flight
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input dftlb_pkg::cfg_reg_t r, input logic [63:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 3'b000};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shadow_write(r, v);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    wait_idle();
    send_overflow(8'h00);
    send_overflow(8'hFF);
    send_overflow(8'h55);
    send_overflow(8'hAA);
  endtask

  task automatic test_duty_scaling();
    wait_idle();
    write_reg(dftlb_pkg::REG_OVERFLOW_PERIOD, 64'hFFFF);
    write_reg(dftlb_pkg::REG_SERVICE_PERIOD, 64'd1);
    write_reg(dftlb_pkg::REG_DAY_LENGTH, 64'd1);
    write_reg(dftlb_pkg::REG_FAN_ON_WINDOW, 64'h1F_FFFF_FFFF);
    write_reg(dftlb_pkg::REG_MIN_FAN_SPEED, 64'd0);
    send_overflow(8'hFF);
    send_overflow(8'hAA);
    send_overflow(8'h00);
    send_overflow(8'hFF);
    wait_idle();
    write_reg(dftlb_pkg::REG_MIN_FAN_SPEED, 64'd255);
    send_overflow(8'h00);
    send_overflow(8'hFF);
    wait_idle();
    write_reg(dftlb_pkg::REG_MIN_FAN_SPEED, 64'd60);
    send_overflow(8'h80);
  endtask

  // fan window, fast blink near day end, wrap past day length
  task automatic test_day_wrap_and_blink();
    wait_idle();
    write_reg(dftlb_pkg::REG_OVERFLOW_PERIOD, 64'd30000);
    write_reg(dftlb_pkg::REG_SERVICE_PERIOD, 64'd10000);
    write_reg(dftlb_pkg::REG_DAY_LENGTH, 64'd100000);
    write_reg(dftlb_pkg::REG_FAN_ON_WINDOW, 64'd30000);
    write_reg(dftlb_pkg::REG_WARNING_WINDOW, 64'd40000);
    write_reg(dftlb_pkg::REG_SLOW_BLINK, 64'd20000);
    write_reg(dftlb_pkg::REG_FAST_BLINK, 64'd0);
    repeat (5) send_overflow(rand_pot());
  endtask

  // clock beyond day length but no update due: no wrap yet
  task automatic test_wrap_needs_service();
    wait_idle();
    write_reg(dftlb_pkg::REG_OVERFLOW_PERIOD, 64'd1000);
    write_reg(dftlb_pkg::REG_SERVICE_PERIOD, 64'd40000);
    write_reg(dftlb_pkg::REG_DAY_LENGTH, 64'h1F_FFFF_FFFF);
    write_reg(dftlb_pkg::REG_FAN_ON_WINDOW, 64'd0);
    send_overflow(rand_pot());
    wait_idle();
    write_reg(dftlb_pkg::REG_DAY_LENGTH, 64'd10);
    send_overflow(rand_pot());
    send_overflow(rand_pot());
    wait_idle();
    write_reg(dftlb_pkg::REG_OVERFLOW_PERIOD, 64'd20000);
    send_overflow(rand_pot());
  endtask

  // clock plus warning window beyond 37 bits must still count as near day end
  task automatic test_wide_warning_sum();
    wait_idle();
    write_reg(dftlb_pkg::REG_OVERFLOW_PERIOD, 64'hFFFF);
    write_reg(dftlb_pkg::REG_SERVICE_PERIOD, 64'd1);
    write_reg(dftlb_pkg::REG_WARNING_WINDOW, 64'h1F_FFFF_FFFF);
    write_reg(dftlb_pkg::REG_DAY_LENGTH, 64'h10_0000_0000);
    write_reg(dftlb_pkg::REG_SLOW_BLINK, 64'hFF_FFFF);
    write_reg(dftlb_pkg::REG_FAST_BLINK, 64'd0);
    repeat (3) send_overflow(rand_pot());
  endtask

  // fan on keeps the blink timer growing until it saturates
  task automatic test_blink_saturation();
    wait_idle();
    write_reg(dftlb_pkg::REG_OVERFLOW_PERIOD, 64'd1000);
    write_reg(dftlb_pkg::REG_SERVICE_PERIOD, 64'hFF_FFFF);
    write_reg(dftlb_pkg::REG_DAY_LENGTH, 64'd1);
    write_reg(dftlb_pkg::REG_FAN_ON_WINDOW, 64'h1F_FFFF_FFFF);
    write_reg(dftlb_pkg::REG_FAST_BLINK, 64'hFF_FFFF);
    repeat (260) send_overflow(rand_pot());
    wait_idle();
    write_reg(dftlb_pkg::REG_FAN_ON_WINDOW, 64'd0);
    repeat (4) send_overflow(rand_pot());
  endtask

  task automatic test_receiver_hold();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_hold = 300;
    repeat (40) send_overflow(rand_pot());
    wait_idle();
    tx_idle_on = 1'b1;
    repeat (10) send_overflow(rand_pot());
  endtask

  task automatic test_random_settings(input int phases, input int beats);
    logic [63:0] svc;
    logic [63:0] ovf;
    repeat (phases) begin
      wait_idle();
      svc = pick_span(1, 6000, 64'hFF_FFFF);
      ovf = pick_span(1, 4000, 64'hFFFF);
      // long service periods need big steps or nothing gets serviced
      if (svc[dftlb_pkg::PER_W-1:0] > 24'd100000) ovf = 64'hFFFF;
      write_reg(dftlb_pkg::REG_SERVICE_PERIOD, svc);
      write_reg(dftlb_pkg::REG_OVERFLOW_PERIOD, ovf);
      write_reg(dftlb_pkg::REG_DAY_LENGTH, pick_span(2000, 150000, 64'h1F_FFFF_FFFF));
      write_reg(dftlb_pkg::REG_FAN_ON_WINDOW, pick_span(0, 150000, 64'h1F_FFFF_FFFF));
      write_reg(dftlb_pkg::REG_WARNING_WINDOW, pick_span(0, 150000, 64'h1F_FFFF_FFFF));
      write_reg(dftlb_pkg::REG_SLOW_BLINK, pick_span(1, 30000, 64'hFF_FFFF));
      write_reg(dftlb_pkg::REG_FAST_BLINK, pick_span(1, 8000, 64'hFF_FFFF));
      write_reg(dftlb_pkg::REG_MIN_FAN_SPEED, pick_span(0, 255, 64'hFF));
      repeat (beats) send_overflow(rand_pot());
    end
  endtask

  // long run with big steps and no idling on either side
  task automatic test_back_to_back();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_reg(dftlb_pkg::REG_OVERFLOW_PERIOD, 64'hFFFF);
    write_reg(dftlb_pkg::REG_SERVICE_PERIOD, 64'hFF_FFFF);
    write_reg(dftlb_pkg::REG_DAY_LENGTH, 64'h1F_FFFF_FFFF);
    write_reg(dftlb_pkg::REG_FAN_ON_WINDOW, 64'h10_0000_0000);
    write_reg(dftlb_pkg::REG_WARNING_WINDOW, 64'h08_0000_0000);
    write_reg(dftlb_pkg::REG_SLOW_BLINK, 64'hFF_FFFF);
    write_reg(dftlb_pkg::REG_FAST_BLINK, 64'h10_0000);
    write_reg(dftlb_pkg::REG_MIN_FAN_SPEED, 64'($urandom_range(0, 255)));
    repeat (110) send_overflow(rand_pot());
  endtask

  initial begin : drive_out_ready
    int gap;
    gap = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_beats
    fan_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        flag_mismatch("unexpected beat", 16'h0, out_tdata);
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata[7:0] !== want.duty)
          flag_mismatch("pwm_duty", 16'(want.duty), 16'(out_tdata[7:0]));
        if (out_tdata[8] !== want.fan)
          flag_mismatch("fan_running", 16'(want.fan), 16'(out_tdata[8]));
        if (out_tdata[9] !== want.led)
          flag_mismatch("led_lit", 16'(want.led), 16'(out_tdata[9]));
        if (out_tdata[10] !== want.serviced)
          flag_mismatch("serviced", 16'(want.serviced), 16'(out_tdata[10]));
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_duty_scaling();
    test_day_wrap_and_blink();
    test_wrap_needs_service();
    test_wide_warning_sum();
    test_blink_saturation();
    test_receiver_hold();
    test_random_settings(10, 60);
    test_back_to_back();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("** daily_fan_timer_with_led_blink: PASSED **");
    end else begin
      $display("** daily_fan_timer_with_led_blink: FAILED **");
    end
    $finish;
  end

endmodule
